>>> sv/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 engine package
// Shared item types, round constants and the SHA-256 mixing functions.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int HSE_QUEUE_DEPTH = 4;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        final_item;
    } hse_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } hse_out_t;

    // One padded message word on its way to the compression core
    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } hse_word_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

endpackage

>>> sv/sha256_front.sv
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts message items, counts bits and emits the padded word stream.
// ----------------------------------------------------------------------------
module sha256_front
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  hse_in_t   in_item,
    output logic      push,
    output hse_word_t push_word,
    input  logic      queue_full
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_PAD80  = 2'd1;
    localparam logic [1:0] PH_ZERO   = 2'd2;
    localparam logic [1:0] PH_LEN_LO = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [63:0] bit_len_reg, bit_len_next;
    logic [3:0]  pos_reg, pos_next;
    logic [2:0]  count;
    logic        accept;

    assign in_stall = queue_full || (phase_reg != PH_IDLE);
    assign accept   = in_valid && !in_stall;
    assign count    = (in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;

    always_comb
    begin
        phase_next     = phase_reg;
        bit_len_next   = bit_len_reg;
        pos_next       = pos_reg;
        push           = 1'b0;
        push_word.word = '0;
        push_word.last = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (accept)
                begin
                    push     = 1'b1;
                    pos_next = pos_reg + 4'd1;
                    if (!in_item.final_item)
                    begin
                        push_word.word = in_item.data_word;
                        bit_len_next   = bit_len_reg + 64'd32;
                    end
                    else
                    begin
                        bit_len_next = bit_len_reg + {58'd0, count, 3'b000};
                        phase_next   = PH_ZERO;
                        unique case (count)
                            3'd0: push_word.word = PAD_WORD;
                            3'd1: push_word.word = {in_item.data_word[31:24], 24'h80_0000};
                            3'd2: push_word.word = {in_item.data_word[31:16], 16'h8000};
                            3'd3: push_word.word = {in_item.data_word[31:8], 8'h80};
                            default:
                            begin
                                push_word.word = in_item.data_word;
                                phase_next     = PH_PAD80;
                            end
                        endcase
                    end
                end
            end
            PH_PAD80:
            begin
                if (!queue_full)
                begin
                    push           = 1'b1;
                    push_word.word = PAD_WORD;
                    pos_next       = pos_reg + 4'd1;
                    phase_next     = PH_ZERO;
                end
            end
            PH_ZERO:
            begin
                if (!queue_full)
                begin
                    push     = 1'b1;
                    pos_next = pos_reg + 4'd1;
                    // length high word lands in slot 14
                    if (pos_reg == 4'd14)
                    begin
                        push_word.word = bit_len_reg[63:32];
                        phase_next     = PH_LEN_LO;
                    end
                end
            end
            default:
            begin
                if (!queue_full)
                begin
                    push           = 1'b1;
                    push_word.word = bit_len_reg[31:0];
                    push_word.last = 1'b1;
                    pos_next       = 4'd0;
                    bit_len_next   = '0;
                    phase_next     = PH_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            bit_len_reg <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            bit_len_reg <= bit_len_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

>>> sv/sha256_queue.sv
// ----------------------------------------------------------------------------
// SHA-256 word queue
// Short FIFO of padded words between the front end and the core.
// ----------------------------------------------------------------------------
module sha256_queue
    import sha256_pkg::*;
#(
    parameter int DEPTH = HSE_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  hse_word_t push_word,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output hse_word_t head_word
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hse_word_t       mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   cnt_reg;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_word = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CW'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

>>> sv/sha256_core.sv
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Loads 16 words, runs 64 rounds, folds into the hash and emits digests.
// ----------------------------------------------------------------------------
module sha256_core
    import sha256_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      word_avail,
    input  hse_word_t head_word,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output hse_out_t  out_item
);

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_ROUND  = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_OUT    = 2'd3;

    logic [1:0]  state_reg;
    logic [3:0]  load_cnt_reg;
    logic [5:0]  round_reg;
    logic [2:0]  idx_reg;
    logic        blk_last_reg;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic        out_valid_reg;
    hse_out_t    out_reg;

    logic [31:0] w_new, t1, t2;
    logic        out_free;

    assign pop       = (state_reg == ST_LOAD) && word_avail;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign w_new = small_sigma1(w_reg[14]) + w_reg[9] + small_sigma0(w_reg[1]) + w_reg[0];
    assign t1 = v_reg[7] + big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[round_reg] + w_reg[0];
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // Schedule window, working variables and output register: payload, no reset
    always_ff @(posedge clk)
    begin
        if (pop || (state_reg == ST_ROUND))
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= (state_reg == ST_ROUND) ? w_new : head_word.word;
        end
        if (pop && (load_cnt_reg == 4'd15))
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (state_reg == ST_ROUND)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if ((state_reg == ST_OUT) && out_free)
        begin
            out_reg.digest_word <= h_reg[idx_reg];
            out_reg.word_index  <= idx_reg;
            out_reg.last_word   <= (idx_reg == 3'd7);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            round_reg     <= '0;
            idx_reg       <= '0;
            blk_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= INIT_H[i];
        end
        else
        begin
            // raise valid with each new digest word, drop it once taken
            if ((state_reg == ST_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_LOAD:
                begin
                    if (pop)
                    begin
                        load_cnt_reg <= load_cnt_reg + 4'd1;
                        if (load_cnt_reg == 4'd15)
                        begin
                            blk_last_reg <= head_word.last;
                            round_reg    <= '0;
                            state_reg    <= ST_ROUND;
                        end
                    end
                end
                ST_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                    if (round_reg == 6'd63)
                        state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    idx_reg   <= '0;
                    state_reg <= blk_last_reg ? ST_OUT : ST_LOAD;
                end
                default:
                begin
                    if (out_free)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            // restart the chaining value for the next message
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= INIT_H[i];
                            state_reg <= ST_LOAD;
                        end
                    end
                end
            endcase
        end
    end

endmodule

>>> sv/sha256_hash_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Streams a message in as 32-bit words, pads it and emits the 8-word digest.
// ----------------------------------------------------------------------------
// Flow: a 16-word block is loaded into the core, run through 64 rounds and
//   folded into the hash in the update state; the digest words follow at
//   one per cycle while out_stall is low.
// Intake: the queue takes items while the single-round core is busy. Padding
//   adds 2 to 18 words after the final item, one per cycle unless queue_full.
// Reset: hash state returns to the initial values, counters and queue clear.
// ----------------------------------------------------------------------------
module sha256_hash_engine
    import sha256_pkg::*;
#(
    parameter int QUEUE_DEPTH = HSE_QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  hse_in_t  in_item,
    output logic     out_valid,
    input  logic     out_stall,
    output hse_out_t out_item
);

    // Front end to queue: padded word stream
    logic      push;
    hse_word_t push_word;
    logic      queue_full;

    // Queue to core: head word and pop
    logic      pop;
    logic      word_avail;
    hse_word_t head_word;

    // Front end: count message bits, insert pad byte, zero fill and length
    sha256_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .push       (push),
        .push_word  (push_word),
        .queue_full (queue_full)
    );

    // Queue: decouple item intake from the compression rounds
    sha256_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (word_avail),
        .head_word (head_word)
    );

    // Core: one round per cycle, output register holds each digest word
    sha256_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_avail (word_avail),
        .head_word  (head_word),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

>>> sim/sha256_hash_engine_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 hash engine testbench
// Streams whole messages into the engine and checks each of the eight digest
// words against a behavioral SHA-256 model kept inside the bench. The model
// pads the message, counts its bits and chains blocks just as the engine
// should. Both channels idle and stall at random, apart from one steady
// stretch with no gaps at all.
// ----------------------------------------------------------------------------
module sha256_hash_engine_tb
    import sha256_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Overall guard on the run, far above the slowest legal schedule
    localparam int CYCLE_LIMIT = 400000;
    // Quiet cycles after the last digest word, so stray results still show up
    localparam int SETTLE_CYCLES = 20;
    // Random items per phase; with the directed tests about 210 in all
    localparam int RANDOM_ITEMS = 100;
    localparam int STEADY_ITEMS = 40;
    localparam int PAUSE_ITEMS  = 20;
    // Percent of cycles in which a channel idles
    localparam int IDLE_PCT = 25;

    localparam logic [31:0] PAD_START = 32'h8000_0000;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] CHAIN_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    hse_in_t  in_item   = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    hse_out_t out_item;

    // Bench-side hash state: chaining value, block being filled, bit count
    logic [31:0] chain_h [8];
    logic [31:0] msg_block [16];
    logic [63:0] msg_bits;
    int          block_fill;

    // Digest words still owed by the engine, oldest first
    hse_out_t digest_q [$];

    int err_count   = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    bit steady_mode = 1'b0;

    sha256_hash_engine u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // SHA-256 model
    // ------------------------------------------------------------------

    function automatic logic [31:0] rot_right(logic [31:0] x, int unsigned n);
        logic [63:0] twice;
        twice = {x, x} >> n;
        return twice[31:0];
    endfunction

    function automatic void restart_chain();
        for (int i = 0; i < 8; i++)
            chain_h[i] = CHAIN_START[i];
        msg_bits   = '0;
        block_fill = 0;
    endfunction

    // Run the 64 rounds over the full block and fold into the chaining value
    function automatic void compress_block();
        logic [31:0] sched [64];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, lo0, lo1;
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                sched[t] = msg_block[t];
            else
            begin
                lo0 = rot_right(sched[t-15], 7) ^ rot_right(sched[t-15], 18)
                      ^ (sched[t-15] >> 3);
                lo1 = rot_right(sched[t-2], 17) ^ rot_right(sched[t-2], 19)
                      ^ (sched[t-2] >> 10);
                sched[t] = sched[t-16] + lo0 + sched[t-7] + lo1;
            end
        end
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
        e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
        for (int t = 0; t < 64; t++)
        begin
            t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25))
                 + ((e & f) ^ (~e & g)) + ROUND_CONST[t] + sched[t];
            t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22))
                 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endfunction

    function automatic void load_word(logic [31:0] w);
        msg_block[block_fill] = w;
        block_fill = (block_fill + 1) % 16;
        if (block_fill == 0)
            compress_block();
    endfunction

    // Absorb one accepted item; on the closing item pad, finish and queue
    // the eight digest words
    function automatic void absorb_item(hse_in_t it);
        int          nbytes;
        logic [31:0] keep;
        hse_out_t    dw;
        if (!it.final_item)
        begin
            // Mid-message items are always full words, whatever the count says
            msg_bits += 64'd32;
            load_word(it.data_word);
        end
        else
        begin
            // Counts above four clamp to a full word
            nbytes = (it.byte_count > 3'd4) ? 4 : int'(it.byte_count);
            msg_bits += 64'(nbytes * 8);
            if (nbytes == 4)
            begin
                load_word(it.data_word);
                load_word(PAD_START);
            end
            else
            begin
                keep = (nbytes == 0) ? 32'h0 : ~(32'hffff_ffff >> (8 * nbytes));
                load_word((it.data_word & keep) | (32'h80 << (24 - 8 * nbytes)));
            end
            while (block_fill != 14)
                load_word(32'h0);
            load_word(msg_bits[63:32]);
            load_word(msg_bits[31:0]);
            for (int i = 0; i < 8; i++)
            begin
                dw.digest_word = chain_h[i];
                dw.word_index  = 3'(i);
                dw.last_word   = (i == 7);
                digest_q.insert(digest_q.size(), dw);
            end
            restart_chain();
        end
    endfunction

    // ------------------------------------------------------------------
    // Channel handling
    // ------------------------------------------------------------------

    // Send one item: optional idle gap, then hold it until accepted.
    // Called at a rising-edge time step; returns at the accepting edge.
    task automatic send_item(hse_in_t it);
        while (!steady_mode && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        absorb_item(it);
        items_sent++;
    endtask

    // Drop valid and hold off until every owed digest word has come back
    task automatic drain_digests();
        in_valid <= 1'b0;
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    // One message of random content; mostly short, now and then a few blocks
    task automatic send_random_message();
        int      nwords;
        hse_in_t it;
        if ($urandom_range(0, 9) == 0)
            nwords = $urandom_range(30, 70);
        else
            nwords = $urandom_range(0, 17);
        for (int i = 0; i < nwords; i++)
        begin
            it.data_word  = $urandom;
            it.byte_count = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            it.final_item = 1'b0;
            send_item(it);
        end
        it.data_word  = $urandom;
        it.byte_count = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(5, 7))
                                                    : 3'($urandom_range(0, 4));
        it.final_item = 1'b1;
        send_item(it);
    endtask

    // Receiver: stall at random except in the steady stretch
    always @(posedge clk)
        out_stall <= !steady_mode && ($urandom_range(0, 99) < IDLE_PCT);

    // Check every accepted digest word against the oldest one owed
    always @(posedge clk)
    begin : check_digest
        hse_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (digest_q.size() == 0)
            begin
                $error("digest word with none owed: word_index %0d, digest_word %h",
                       out_item.word_index, out_item.digest_word);
                err_count++;
            end
            else
            begin
                want = digest_q.pop_front();
                if (out_item.digest_word !== want.digest_word)
                begin
                    $error("digest_word: expected %h, got %h",
                           want.digest_word, out_item.digest_word);
                    err_count++;
                end
                if (out_item.word_index !== want.word_index)
                begin
                    $error("word_index: expected %0d, got %0d",
                           want.word_index, out_item.word_index);
                    err_count++;
                end
                if (out_item.last_word !== want.last_word)
                begin
                    $error("last_word: expected %b, got %b",
                           want.last_word, out_item.last_word);
                    err_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sha256_hash_engine_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty message, a three-byte message, and a message whose last item
    // is a full word so the pad byte opens a fresh word
    task automatic test_short_messages();
        hse_in_t it;
        it = '{data_word: $urandom, byte_count: 3'd0, final_item: 1'b1};
        send_item(it);
        it = '{data_word: 32'h6162_63ff, byte_count: 3'd3, final_item: 1'b1};
        send_item(it);
        it = '{data_word: 32'h0000_0000, byte_count: 3'd4, final_item: 1'b1};
        send_item(it);
    endtask

    // Field extremes: a mid-message item with a zero byte count still counts
    // as a full word; a closing count of seven clamps to four
    task automatic test_field_extremes();
        hse_in_t it;
        it = '{data_word: 32'hffff_ffff, byte_count: 3'd0, final_item: 1'b0};
        send_item(it);
        it = '{data_word: 32'h0000_0000, byte_count: 3'd7, final_item: 1'b1};
        send_item(it);
        it = '{data_word: 32'h0000_0000, byte_count: 3'd7, final_item: 1'b0};
        send_item(it);
        it = '{data_word: 32'hffff_ffff, byte_count: 3'd1, final_item: 1'b1};
        send_item(it);
    endtask

    // Fourteen full words then an empty close: the pad lands in slot 14,
    // so the length spills into a second padding block
    task automatic test_block_boundary();
        hse_in_t it;
        for (int i = 0; i < 14; i++)
        begin
            it = '{data_word: $urandom, byte_count: 3'd4, final_item: 1'b0};
            send_item(it);
        end
        it = '{data_word: $urandom, byte_count: 3'd0, final_item: 1'b1};
        send_item(it);
    endtask

    task automatic test_random_messages();
        int start;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
            send_random_message();
    endtask

    // Back-to-back traffic with neither side idling
    task automatic test_steady_stream();
        int start;
        start = items_sent;
        steady_mode = 1'b1;
        while (items_sent - start < STEADY_ITEMS)
            send_random_message();
        steady_mode = 1'b0;
    endtask

    // Hold the sender after each message until its digest is fully out
    task automatic test_drain_pause();
        int start;
        start = items_sent;
        while (items_sent - start < PAUSE_ITEMS)
        begin
            send_random_message();
            drain_digests();
            @(posedge clk);
        end
    endtask

    initial
    begin
        restart_chain();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_messages();
        test_field_extremes();
        test_block_boundary();
        test_random_messages();
        test_steady_stream();
        test_drain_pause();

        // Let the last digest out, then watch for anything extra
        drain_digests();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("sha256_hash_engine_tb: done, clean");
        else
            $display("sha256_hash_engine_tb: done, errors");
        $finish;
    end

endmodule
